@@ rtl/core/assert_macros.svh @@
// Assertion macros for the plus code decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif

`endif

@@ rtl/core/pcd_pkg.sv @@
// Types, constants and lookup functions for the plus code decoder.
package pcd_pkg;

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_FOLD    = 8'h20;

    localparam logic [4:0] SEP_POS     = 5'd8;
    localparam logic [4:0] AFTER_SEP   = 5'd9;
    localparam logic [4:0] POS_MAX     = 5'd31;
    localparam logic [4:0] PAIR_DIGITS = 5'd10;
    localparam logic [4:0] FIRST_MAX   = 5'd8;
    localparam logic [4:0] SECOND_MAX  = 5'd17;

    localparam logic [7:0] LAT_FINE = 8'd125;
    localparam logic [6:0] LON_FINE = 7'd64;

    // Accumulators start at minus the corner offsets, two's complement.
    localparam logic [32:0] LAT_BASE = 33'd6339934592;
    localparam logic [31:0] LON_BASE = 32'd2820407296;

    // Resolution of a code with no pair at all, reduced modulo the field width.
    localparam logic [33:0] LAT_FULL_WIDE = 34'd10000000000;
    localparam logic [32:0] LAT_FULL      = LAT_FULL_WIDE[32:0];
    localparam logic [31:0] LON_FULL      = 32'd3276800000;

    typedef struct packed {
        logic       ok;
        logic [4:0] val;
    } symbol_t;

    typedef struct packed {
        logic        code_ok;
        logic [4:0]  digits;
        logic [32:0] lat_acc;
        logic [6:0]  lat_rem;
        logic [31:0] lon_acc;
        logic [5:0]  lon_rem;
    } fin_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            return c - CASE_FOLD;
        end
        return c;
    endfunction

    function automatic symbol_t symbol_lookup(input logic [7:0] c);
        symbol_t s;
        s.ok = 1'b1;
        unique case (c)
            8'h32:   s.val = 5'd0;
            8'h33:   s.val = 5'd1;
            8'h34:   s.val = 5'd2;
            8'h35:   s.val = 5'd3;
            8'h36:   s.val = 5'd4;
            8'h37:   s.val = 5'd5;
            8'h38:   s.val = 5'd6;
            8'h39:   s.val = 5'd7;
            8'h43:   s.val = 5'd8;
            8'h46:   s.val = 5'd9;
            8'h47:   s.val = 5'd10;
            8'h48:   s.val = 5'd11;
            8'h4A:   s.val = 5'd12;
            8'h4D:   s.val = 5'd13;
            8'h50:   s.val = 5'd14;
            8'h51:   s.val = 5'd15;
            8'h52:   s.val = 5'd16;
            8'h56:   s.val = 5'd17;
            8'h57:   s.val = 5'd18;
            8'h58:   s.val = 5'd19;
            default: begin
                s.ok  = 1'b0;
                s.val = 5'd0;
            end
        endcase
        return s;
    endfunction

    // Pair weights in output units, index = pair number.
    function automatic logic [28:0] lat_pair_w(input logic [2:0] k);
        unique case (k)
            3'd0:    return 29'd500000000;
            3'd1:    return 29'd25000000;
            3'd2:    return 29'd1250000;
            3'd3:    return 29'd62500;
            3'd4:    return 29'd3125;
            default: return 29'd0;
        endcase
    endfunction

    function automatic logic [27:0] lon_pair_w(input logic [2:0] k);
        unique case (k)
            3'd0:    return 28'd163840000;
            3'd1:    return 28'd8192000;
            3'd2:    return 28'd409600;
            3'd3:    return 28'd20480;
            3'd4:    return 28'd1024;
            default: return 28'd0;
        endcase
    endfunction

    // Grid weights split into whole output units and a fine remainder.
    function automatic logic [9:0] lat_grid_q(input logic [2:0] g);
        unique case (g)
            3'd0:    return 10'd625;
            3'd1:    return 10'd125;
            3'd2:    return 10'd25;
            3'd3:    return 10'd5;
            3'd4:    return 10'd1;
            default: return 10'd0;
        endcase
    endfunction

    function automatic logic [4:0] lat_grid_r(input logic [2:0] g);
        unique case (g)
            3'd5:    return 5'd25;
            3'd6:    return 5'd5;
            3'd7:    return 5'd1;
            default: return 5'd0;
        endcase
    endfunction

    function automatic logic [8:0] lon_grid_q(input logic [2:0] g);
        unique case (g)
            3'd0:    return 9'd256;
            3'd1:    return 9'd64;
            3'd2:    return 9'd16;
            3'd3:    return 9'd4;
            3'd4:    return 9'd1;
            default: return 9'd0;
        endcase
    endfunction

    function automatic logic [4:0] lon_grid_r(input logic [2:0] g);
        unique case (g)
            3'd5:    return 5'd16;
            3'd6:    return 5'd4;
            3'd7:    return 5'd1;
            default: return 5'd0;
        endcase
    endfunction

endpackage

@@ rtl/core/pcd_accum.sv @@
// Character checker and digit accumulator of the plus code decoder.
`include "assert_macros.svh"

module pcd_accum #(
    parameter int MAX_GRID_DIGITS = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_char,
    input  logic          in_last,
    output logic          fin_valid,
    input  logic          fin_ready,
    output pcd_pkg::fin_t fin
);

    localparam int GRID_LIMIT = (MAX_GRID_DIGITS < 1) ? 1 :
                                (MAX_GRID_DIGITS > 8) ? 8 : MAX_GRID_DIGITS;

    logic          in_valid_reg;
    logic [7:0]    char_reg;
    logic          last_reg;
    logic [4:0]    pos_reg;
    logic [4:0]    digits_reg;
    logic          sep_reg;
    logic          pad_reg;
    logic          broken_reg;
    logic [32:0]   lat_acc_reg;
    logic [6:0]    lat_rem_reg;
    logic [31:0]   lon_acc_reg;
    logic [5:0]    lon_rem_reg;
    logic          fin_valid_reg;
    pcd_pkg::fin_t fin_reg;

    logic             advance;
    logic             take_last;
    logic [7:0]       c_up;
    pcd_pkg::symbol_t sym;
    logic             broken_next;
    logic             sep_next;
    logic             pad_next;
    logic             add_en;
    logic [4:0]       digits_next;
    logic [4:0]       pos_next;
    logic [4:0]       dm10;
    logic [2:0]       gi;
    logic             pair_on;
    logic             grid_on;
    logic [4:0]       lat_mul;
    logic [28:0]      lat_w;
    logic [4:0]       lon_mul;
    logic [27:0]      lon_w;
    logic [33:0]      lat_prod;
    logic [32:0]      lon_prod;
    logic [7:0]       lat_rprod;
    logic [6:0]       lon_rprod;
    logic [32:0]      lat_acc_next;
    logic [6:0]       lat_rem_next;
    logic [31:0]      lon_acc_next;
    logic [5:0]       lon_rem_next;
    logic             final_broken;

    assign advance   = in_valid_reg && (!last_reg || !fin_valid_reg || fin_ready);
    assign take_last = advance && last_reg;
    assign in_ready  = !in_valid_reg || advance;
    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

    always_comb begin
        c_up        = pcd_pkg::fold_case(char_reg);
        sym         = pcd_pkg::symbol_lookup(c_up);
        broken_next = broken_reg;
        sep_next    = sep_reg;
        pad_next    = pad_reg;
        add_en      = 1'b0;
        if (c_up == pcd_pkg::CHAR_PLUS) begin
            if (sep_reg || pos_reg != pcd_pkg::SEP_POS) begin
                broken_next = 1'b1;
            end else begin
                sep_next = 1'b1;
            end
        end else if (pos_reg < pcd_pkg::SEP_POS) begin
            if (pos_reg == 5'd0 && (!sym.ok || sym.val > pcd_pkg::FIRST_MAX)) begin
                broken_next = 1'b1;
            end
            if (pos_reg == 5'd1 && (!sym.ok || sym.val > pcd_pkg::SECOND_MAX)) begin
                broken_next = 1'b1;
            end
            priority if (pad_reg) begin
                if (c_up != pcd_pkg::CHAR_ZERO) begin
                    broken_next = 1'b1;
                end
            end else if (sym.ok) begin
                add_en = 1'b1;
            end else if (c_up == pcd_pkg::CHAR_ZERO) begin
                pad_next = 1'b1;
                if (pos_reg[0]) begin
                    broken_next = 1'b1;
                end
            end else begin
                broken_next = 1'b1;
            end
        end else if (!sep_reg) begin
            broken_next = 1'b1;
        end else if (pad_reg || !sym.ok) begin
            broken_next = 1'b1;
        end else begin
            add_en = 1'b1;
        end
    end

    always_comb begin
        dm10    = digits_reg - pcd_pkg::PAIR_DIGITS;
        gi      = dm10[2:0];
        pair_on = add_en && (digits_reg < pcd_pkg::PAIR_DIGITS);
        grid_on = add_en && (digits_reg >= pcd_pkg::PAIR_DIGITS)
                  && (dm10 < 5'(GRID_LIMIT));
        lat_mul   = 5'd0;
        lat_w     = 29'd0;
        lon_mul   = 5'd0;
        lon_w     = 28'd0;
        lat_rprod = 8'd0;
        lon_rprod = 7'd0;
        if (pair_on) begin
            if (digits_reg[0]) begin
                lon_mul = sym.val;
                lon_w   = pcd_pkg::lon_pair_w(digits_reg[3:1]);
            end else begin
                lat_mul = sym.val;
                lat_w   = pcd_pkg::lat_pair_w(digits_reg[3:1]);
            end
        end else if (grid_on) begin
            lat_mul   = {2'b00, sym.val[4:2]};
            lat_w     = {19'd0, pcd_pkg::lat_grid_q(gi)};
            lon_mul   = {3'b000, sym.val[1:0]};
            lon_w     = {19'd0, pcd_pkg::lon_grid_q(gi)};
            lat_rprod = 8'(sym.val[4:2]) * 8'(pcd_pkg::lat_grid_r(gi));
            lon_rprod = 7'(sym.val[1:0]) * 7'(pcd_pkg::lon_grid_r(gi));
        end
        lat_prod     = 34'(lat_mul) * 34'(lat_w);
        lon_prod     = 33'(lon_mul) * 33'(lon_w);
        lat_acc_next = lat_acc_reg + lat_prod[32:0];
        lon_acc_next = lon_acc_reg + lon_prod[31:0];
        lat_rem_next = lat_rem_reg + lat_rprod[6:0];
        lon_rem_next = lon_rem_reg + lon_rprod[5:0];
        digits_next  = (add_en && digits_reg != pcd_pkg::POS_MAX) ?
                       digits_reg + 5'd1 : digits_reg;
        pos_next     = (pos_reg != pcd_pkg::POS_MAX) ? pos_reg + 5'd1 : pos_reg;
        final_broken = broken_next || !sep_next || (pos_reg == pcd_pkg::AFTER_SEP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            char_reg <= in_char;
            last_reg <= in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || take_last) begin
            pos_reg     <= 5'd0;
            digits_reg  <= 5'd0;
            sep_reg     <= 1'b0;
            pad_reg     <= 1'b0;
            broken_reg  <= 1'b0;
            lat_acc_reg <= pcd_pkg::LAT_BASE;
            lat_rem_reg <= 7'd0;
            lon_acc_reg <= pcd_pkg::LON_BASE;
            lon_rem_reg <= 6'd0;
        end else if (advance) begin
            pos_reg     <= pos_next;
            digits_reg  <= digits_next;
            sep_reg     <= sep_next;
            pad_reg     <= pad_next;
            broken_reg  <= broken_next;
            lat_acc_reg <= lat_acc_next;
            lat_rem_reg <= lat_rem_next;
            lon_acc_reg <= lon_acc_next;
            lon_rem_reg <= lon_rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (take_last) begin
            fin_valid_reg <= 1'b1;
        end else if (fin_ready) begin
            fin_valid_reg <= 1'b0;
        end
        if (take_last) begin
            fin_reg.code_ok <= !final_broken;
            fin_reg.digits  <= digits_next;
            fin_reg.lat_acc <= lat_acc_next;
            fin_reg.lat_rem <= lat_rem_next;
            fin_reg.lon_acc <= lon_acc_next;
            fin_reg.lon_rem <= lon_rem_next;
        end
    end

    `ASSERT_CLK(a_clear_after_last, aclk, aresetn, take_last |=> (pos_reg == 5'd0 && !sep_reg))
    `ASSERT_NEVER(a_lat_rem_range, aclk, aresetn, lat_rem_reg >= 7'd125)
    `ASSERT_NEVER(a_digits_le_pos, aclk, aresetn, digits_reg > pos_reg)
    `ASSERT_NEVER(a_sep_position, aclk, aresetn, sep_reg && pos_reg < pcd_pkg::AFTER_SEP)

endmodule

@@ rtl/core/pcd_corner.sv @@
// Box corner stage and output register of the plus code decoder.
module pcd_corner #(
    parameter int MAX_GRID_DIGITS = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fin_valid,
    output logic          fin_ready,
    input  pcd_pkg::fin_t fin,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          out_code_valid,
    output logic [32:0]   out_south,
    output logic [32:0]   out_north,
    output logic [31:0]   out_west,
    output logic [31:0]   out_east
);

    localparam int GRID_LIMIT = (MAX_GRID_DIGITS < 1) ? 1 :
                                (MAX_GRID_DIGITS > 8) ? 8 : MAX_GRID_DIGITS;

    logic        out_valid_reg;
    logic        code_ok_reg;
    logic [32:0] south_reg;
    logic [32:0] north_reg;
    logic [31:0] west_reg;
    logic [31:0] east_reg;

    logic [2:0]  pair_k;
    logic [4:0]  dm10;
    logic [4:0]  g_sat;
    logic [4:0]  g_idx;
    logic [32:0] lat_res_q;
    logic [4:0]  lat_res_r;
    logic [31:0] lon_res_q;
    logic [4:0]  lon_res_r;
    logic [7:0]  lat_rsum;
    logic [6:0]  lon_rsum;
    logic        lat_carry;
    logic        lon_carry;
    logic [32:0] north_calc;
    logic [31:0] east_calc;
    logic [4:0]  pair_half;

    assign fin_ready      = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign out_code_valid = code_ok_reg;
    assign out_south      = south_reg;
    assign out_north      = north_reg;
    assign out_west       = west_reg;
    assign out_east       = east_reg;

    always_comb begin
        pair_half = {1'b0, fin.digits[4:1]} - 5'd1;
        pair_k    = pair_half[2:0];
        dm10      = fin.digits - pcd_pkg::PAIR_DIGITS;
        g_sat     = (dm10 > 5'(GRID_LIMIT)) ? 5'(GRID_LIMIT) : dm10;
        g_idx     = g_sat - 5'd1;
        lat_res_r = 5'd0;
        lon_res_r = 5'd0;
        priority if (fin.digits < 5'd2) begin
            lat_res_q = pcd_pkg::LAT_FULL;
            lon_res_q = pcd_pkg::LON_FULL;
        end else if (fin.digits <= pcd_pkg::PAIR_DIGITS) begin
            lat_res_q = {4'd0, pcd_pkg::lat_pair_w(pair_k)};
            lon_res_q = {4'd0, pcd_pkg::lon_pair_w(pair_k)};
        end else begin
            lat_res_q = {23'd0, pcd_pkg::lat_grid_q(g_idx[2:0])};
            lon_res_q = {23'd0, pcd_pkg::lon_grid_q(g_idx[2:0])};
            lat_res_r = pcd_pkg::lat_grid_r(g_idx[2:0]);
            lon_res_r = pcd_pkg::lon_grid_r(g_idx[2:0]);
        end
        lat_rsum   = {1'b0, fin.lat_rem} + {3'd0, lat_res_r};
        lon_rsum   = {1'b0, fin.lon_rem} + {2'd0, lon_res_r};
        lat_carry  = lat_rsum >= pcd_pkg::LAT_FINE;
        lon_carry  = lon_rsum >= pcd_pkg::LON_FINE;
        north_calc = fin.lat_acc + lat_res_q + {32'd0, lat_carry};
        east_calc  = fin.lon_acc + lon_res_q + {31'd0, lon_carry};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fin_ready) begin
            out_valid_reg <= fin_valid;
        end
        if (fin_ready && fin_valid) begin
            code_ok_reg <= fin.code_ok;
            south_reg   <= fin.code_ok ? fin.lat_acc : 33'd0;
            north_reg   <= fin.code_ok ? north_calc : 33'd0;
            west_reg    <= fin.code_ok ? fin.lon_acc : 32'd0;
            east_reg    <= fin.code_ok ? east_calc : 32'd0;
        end
    end

endmodule

@@ rtl/core/plus_code_decoder_top.sv @@
// Top level of the plus code decoder: character stream in, decoded box out.
//
// Input channel s_axis: one ASCII character of a full plus code per word,
// lower case folded to upper case; s_axis_tlast marks the final character.
// Output channel m_axis: one word per code, issued for the character marked
// last; m_axis_tuser is the valid flag and tdata carries the box corners
// (latitude in 1/25,000,000 degree, longitude in 1/8,192,000 degree, signed).
// Corners are zero when the flag is low.
// Throughput: one character per cycle unless a final character is held back; the per-character check
// and the position-weighted digit add both work on the character in the input register, combinationally.
// m_axis_tvalid rises once the final character has passed the input register, the accumulator result
// register and the corner output register.
// A stalled receiver holds the output word; characters of the next code keep
// flowing until the next final character meets both result registers full.
// Reset (aresetn low, synchronous) empties all registers and clears the
// decoder state; every final character also returns it to that state.
module plus_code_decoder_top #(
    parameter int MAX_GRID_DIGITS = 5
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] code_char
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,   // south_lat, north_lat, west_lon, east_lon, zero fill
    output logic         m_axis_tuser    // code_valid
);

    logic          fin_valid;
    logic          fin_ready;
    pcd_pkg::fin_t fin;
    logic [32:0]   south;
    logic [32:0]   north;
    logic [31:0]   west;
    logic [31:0]   east;

    pcd_accum #(
        .MAX_GRID_DIGITS(MAX_GRID_DIGITS)
    ) u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_char   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin)
    );

    pcd_corner #(
        .MAX_GRID_DIGITS(MAX_GRID_DIGITS)
    ) u_corner (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fin_valid      (fin_valid),
        .fin_ready      (fin_ready),
        .fin            (fin),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_code_valid (m_axis_tuser),
        .out_south      (south),
        .out_north      (north),
        .out_west       (west),
        .out_east       (east)
    );

    assign m_axis_tdata = {6'd0, east, west, north, south};

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the plus code decoder top level.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_GRID     = 5;
    localparam int GRID_LIMIT   = (MAX_GRID < 1) ? 1 : ((MAX_GRID > 8) ? 8 : MAX_GRID);
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_CHARS  = 175;
    localparam logic [159:0] ALPHABET = "23456789CFGHJMPQRVWX";

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } char_word_t;

    typedef struct packed {
        logic        ok;
        logic [32:0] south;
        logic [32:0] north;
        logic [31:0] west;
        logic [31:0] east;
    } box_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;   // [7:0] code_char
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;           // south_lat, north_lat, west_lon, east_lon, zero fill
    logic         m_axis_tuser;           // code_valid

    char_word_t   char_q[$];
    box_t         boxes_due[$];
    logic [7:0]   code_buf[$];
    char_word_t   next_word;

    // decoder state mirror
    logic [4:0]   char_pos = '0;
    logic [4:0]   digits = '0;
    logic         sep_seen = 1'b0;
    logic         pad_on = 1'b0;
    logic         broken = 1'b0;
    logic [63:0]  lat_acc = '0;
    logic [63:0]  lon_acc = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int hold_left = 0;
    int quiet = 0;
    int errors = 0;
    int random_chars = 0;

    plus_code_decoder_top #(
        .MAX_GRID_DIGITS (MAX_GRID)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 aclk = ~aclk;

    function automatic logic [7:0] sym_char(input int i);
        return ALPHABET[159 - 8 * i -: 8];
    endfunction

    function automatic int symbol_index(input logic [7:0] c);
        for (int i = 0; i < 20; i++) begin
            if (sym_char(i) == c) begin
                return i;
            end
        end
        return -1;
    endfunction

    // k 0..4: pair weights; k 5..12: grid weights, all in fine units
    function automatic logic [63:0] lat_weight(input int k);
        case (k)
            0: return 64'd62500000000;
            1: return 64'd3125000000;
            2: return 64'd156250000;
            3: return 64'd7812500;
            4: return 64'd390625;
            5: return 64'd78125;
            6: return 64'd15625;
            7: return 64'd3125;
            8: return 64'd625;
            9: return 64'd125;
            10: return 64'd25;
            11: return 64'd5;
            12: return 64'd1;
            default: return 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] lon_weight(input int k);
        case (k)
            0: return 64'd10485760000;
            1: return 64'd524288000;
            2: return 64'd26214400;
            3: return 64'd1310720;
            4: return 64'd65536;
            5: return 64'd16384;
            6: return 64'd4096;
            7: return 64'd1024;
            8: return 64'd256;
            9: return 64'd64;
            10: return 64'd16;
            11: return 64'd4;
            12: return 64'd1;
            default: return 64'd0;
        endcase
    endfunction

    task automatic add_symbol(input int v);
        int g;
        g = int'(digits) - 10;
        if (digits < 5'd10) begin
            if (!digits[0]) begin
                lat_acc = lat_acc + lat_weight(int'(digits >> 1)) * 64'(v);
            end else begin
                lon_acc = lon_acc + lon_weight(int'(digits >> 1)) * 64'(v);
            end
        end else if (g < GRID_LIMIT) begin
            lat_acc = lat_acc + lat_weight(5 + g) * 64'(v / 4);
            lon_acc = lon_acc + lon_weight(5 + g) * 64'(v % 4);
        end
        if (digits != pcd_pkg::POS_MAX) begin
            digits = digits + 5'd1;
        end
    endtask

    task automatic take_char(input logic [7:0] raw, input logic fin);
        logic [7:0]  c;
        logic [4:0]  p;
        int          v;
        int          g;
        logic [63:0] lat_span;
        logic [63:0] lon_span;
        longint      edge_val;
        box_t        box;
        c = raw;
        p = char_pos;
        if (c >= pcd_pkg::CHAR_LOWER_A && c <= pcd_pkg::CHAR_LOWER_Z) begin
            c = c - pcd_pkg::CASE_FOLD;
        end
        v = symbol_index(c);
        if (c == pcd_pkg::CHAR_PLUS) begin
            if (sep_seen || p != pcd_pkg::SEP_POS) begin
                broken = 1'b1;
            end else begin
                sep_seen = 1'b1;
            end
        end else if (p < pcd_pkg::SEP_POS) begin
            if (p == 5'd0 && (v < 0 || v > int'(pcd_pkg::FIRST_MAX))) begin
                broken = 1'b1;
            end
            if (p == 5'd1 && (v < 0 || v > int'(pcd_pkg::SECOND_MAX))) begin
                broken = 1'b1;
            end
            if (pad_on) begin
                if (c != pcd_pkg::CHAR_ZERO) begin
                    broken = 1'b1;
                end
            end else if (v >= 0) begin
                add_symbol(v);
            end else if (c == pcd_pkg::CHAR_ZERO) begin
                pad_on = 1'b1;
                if (p[0]) begin
                    broken = 1'b1;
                end
            end else begin
                broken = 1'b1;
            end
        end else if (!sep_seen) begin
            broken = 1'b1;
        end else if (pad_on || v < 0) begin
            broken = 1'b1;
        end else begin
            add_symbol(v);
        end
        if (char_pos != pcd_pkg::POS_MAX) begin
            char_pos = char_pos + 5'd1;
        end
        if (fin) begin
            if (!sep_seen || p == pcd_pkg::AFTER_SEP) begin
                broken = 1'b1;
            end
            box = '0;
            if (!broken) begin
                if (digits < 5'd2) begin
                    lat_span = lat_weight(0) * 64'd20;
                    lon_span = lon_weight(0) * 64'd20;
                end else if (digits <= 5'd10) begin
                    lat_span = lat_weight(int'(digits >> 1) - 1);
                    lon_span = lon_weight(int'(digits >> 1) - 1);
                end else begin
                    g = int'(digits) - 10;
                    if (g > GRID_LIMIT) begin
                        g = GRID_LIMIT;
                    end
                    lat_span = lat_weight(4 + g);
                    lon_span = lon_weight(4 + g);
                end
                box.ok = 1'b1;
                edge_val = $signed(lat_acc / 64'd125) - 64'sd2250000000;
                box.south = edge_val[32:0];
                edge_val = $signed((lat_acc + lat_span) / 64'd125) - 64'sd2250000000;
                box.north = edge_val[32:0];
                edge_val = $signed(lon_acc / 64'd64) - 64'sd1474560000;
                box.west = edge_val[31:0];
                edge_val = $signed((lon_acc + lon_span) / 64'd64) - 64'sd1474560000;
                box.east = edge_val[31:0];
            end
            boxes_due.push_back(box);
            char_pos = '0;
            digits = '0;
            sep_seen = 1'b0;
            pad_on = 1'b0;
            broken = 1'b0;
            lat_acc = '0;
            lon_acc = '0;
        end
    endtask

    task automatic flush_code();
        char_word_t w;
        for (int i = 0; i < code_buf.size(); i++) begin
            w.ch = code_buf[i];
            w.fin = (i == code_buf.size() - 1);
            char_q.push_back(w);
        end
    endtask

    task automatic queue_text(input string s);
        code_buf.delete();
        for (int i = 0; i < s.len(); i++) begin
            code_buf.push_back(s[i]);
        end
        flush_code();
    endtask

    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z" && $urandom_range(0, 2) == 0) begin
            return c + pcd_pkg::CASE_FOLD;
        end
        return c;
    endfunction

    task automatic queue_random_code();
        int kind;
        int n;
        int trail;
        int r;
        int p;
        int sym;
        code_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 9);
                if (r < 3) begin
                    code_buf.push_back(8'($urandom_range(0, 255)));
                end else if (r < 5) begin
                    code_buf.push_back(pcd_pkg::CHAR_ZERO);
                end else if (r == 5) begin
                    code_buf.push_back(pcd_pkg::CHAR_PLUS);
                end else begin
                    code_buf.push_back(mixed_case(sym_char($urandom_range(0, 19))));
                end
            end
        end else begin
            n = 2 * $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                sym = (i == 0) ? $urandom_range(0, 8) :
                      (i == 1) ? $urandom_range(0, 17) : $urandom_range(0, 19);
                code_buf.push_back(mixed_case(sym_char(sym)));
            end
            for (int i = n; i < 8; i++) begin
                code_buf.push_back(pcd_pkg::CHAR_ZERO);
            end
            code_buf.push_back(pcd_pkg::CHAR_PLUS);
            if (n == 8) begin
                r = $urandom_range(0, 19);
                trail = (r < 3) ? 0 : (r < 16) ? $urandom_range(2, 7) : $urandom_range(8, 26);
                for (int i = 0; i < trail; i++) begin
                    code_buf.push_back(mixed_case(sym_char($urandom_range(0, 19))));
                end
            end
            if (kind < 35) begin
                p = $urandom_range(0, code_buf.size() - 1);
                case ($urandom_range(0, 6))
                    0: code_buf[p] = 8'($urandom_range(0, 255));
                    1: code_buf[p] = pcd_pkg::CHAR_ZERO;
                    2: code_buf[p] = pcd_pkg::CHAR_PLUS;
                    3: if (code_buf.size() > 1) code_buf.delete(p);
                    4: code_buf.insert(p, 8'($urandom_range(0, 255)));
                    5: begin
                        if (code_buf.size() == 9) begin
                            code_buf.push_back(sym_char($urandom_range(0, 19)));
                        end
                        while (code_buf.size() > 10) begin
                            void'(code_buf.pop_back());
                        end
                    end
                    default: code_buf.delete(8);
                endcase
            end
        end
        random_chars += code_buf.size();
        flush_code();
    endtask

    task automatic wait_drained();
        while (char_q.size() != 0 || s_axis_tvalid || boxes_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                take_char(s_axis_tdata, s_axis_tlast);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (char_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_word = char_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_word.ch;
                    s_axis_tlast  <= next_word.fin;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls and the long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            hold_left <= 0;
        end else if (holds_done != hold_requests) begin
            holds_done <= holds_done + 1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // result check
    always @(posedge aclk) begin
        box_t got;
        box_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.ok    = m_axis_tuser;
            got.south = m_axis_tdata[32:0];
            got.north = m_axis_tdata[65:33];
            got.west  = m_axis_tdata[97:66];
            got.east  = m_axis_tdata[129:98];
            if (boxes_due.size() == 0) begin
                if (errors < 10) begin
                    $display("unexpected result word: ok=%0b s=%0d n=%0d w=%0d e=%0d",
                             got.ok, $signed(got.south), $signed(got.north),
                             $signed(got.west), $signed(got.east));
                end
                errors <= errors + 1;
            end else begin
                want = boxes_due.pop_front();
                if (got.ok != want.ok || got.south != want.south || got.north != want.north
                        || got.west != want.west || got.east != want.east) begin
                    if (errors < 10) begin
                        $display("box mismatch: exp ok=%0b s=%0d n=%0d w=%0d e=%0d",
                                 want.ok, $signed(want.south), $signed(want.north),
                                 $signed(want.west), $signed(want.east));
                        $display("              got ok=%0b s=%0d n=%0d w=%0d e=%0d",
                                 got.ok, $signed(got.south), $signed(got.north),
                                 $signed(got.west), $signed(got.east));
                    end
                    errors <= errors + 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        queue_text("8FVC9G8F+6X");
        queue_text("8fvc9g8f+6xgh5w4r");
        queue_text("CVXXXXXX+XXXXXXXXXXX");
        queue_text("22000000+");
        queue_text("CW000000+");
        queue_text("F2000000+");
        queue_text("22200000+");
        queue_text("2200C000+");
        queue_text("22000000+22");
        queue_text("8FVC9G8F+6");
        queue_text("8FVC+9G8F");
        queue_text("8FVC9G8F++");
        queue_text("8FVC9G8F");
        queue_text("8FVC9G8F+6X!");
        queue_text("8FVC9G8F+XXXXXXXXXXXXXXXXXXXXXXXX");
        queue_text("+");
        code_buf.delete();
        code_buf.push_back(8'h00);
        code_buf.push_back(8'hFF);
        flush_code();
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 85; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 85; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            while (random_chars < PHASE_CHARS * (phase + 1)) begin
                queue_random_code();
            end
            if (phase == 0) begin
                hold_requests = hold_requests + 1;
            end
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
